// ===== rtl/rdds_pkg.sv =====
// Shared codes, constants and percent scaling for the rumble delay/duration scheduler.
package rdds_pkg;

    // Input word command codes
    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_PLAY   = 2'd1,
        CMD_STATUS = 2'd2
    } cmd_t;

    // Link send status codes (any other value is treated as a hard error)
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_DISALLOWED = 2'd1;

    // Configuration register index (byte address bit 2)
    typedef enum logic {
        REG_BLE_MODE = 1'b0,
        REG_RETRY_MS = 1'b1
    } reg_idx_t;

    localparam logic [15:0] RETRY_RESET        = 16'd50;
    localparam logic [15:0] PCT_FULL           = 16'd100;
    localparam logic [7:0]  PLAY_DURATION_CODE = 8'hff;
    localparam logic [7:0]  PLAY_LOOPS         = 8'd25;
    localparam logic [3:0]  MASK_ALL_OFF       = 4'hf;

    // level * 100 / 255, integer division; divide by 255 done as
    // (p + (p >> 8) + 1) >> 8, exact for p below 65535
    function automatic logic [6:0] to_pct(input logic [7:0] level);
        logic [15:0] prod;
        logic [15:0] sum;
        prod = 16'(level) * PCT_FULL;
        sum  = prod + (prod >> 8) + 16'd1;
        return sum[14:8];
    endfunction

endpackage

// ===== rtl/rumble_delay_duration_scheduler.sv =====
// Top level of the rumble delay/duration scheduler: input stage, scheduler state, report register.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one word per tick, play request or
//   link status, selected by command. Output channel (out_valid/out_ready)
//   carries motor reports: a play report (mask, four percent levels, duration
//   code 255, loops 25) or an all-off report (mask 15, zeros).
//   The APB port holds ble_mode (0x0) and retry_ms (0x4); write it only while
//   the block is idle. In BLE mode each report sets expects_status and the
//   caller must answer with a link status word.
// Flow:
//   A word is registered in the input stage on accept and processed from there
//   once the report register can advance; its report is then loaded into the
//   report register. One word per cycle is taken as long as the report register is
//   empty or being read.
// Stall: when out_ready is low with a report pending, one more word is held in
//   the input stage and in_ready then drops until the report is taken.
// Reset: rst_n clears the stages, phase goes to disabled, counters and latched
//   levels go to zero, ble_mode to 0 and retry_ms to 50.
module rumble_delay_duration_scheduler
    import rdds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [15:0] start_delay,
    input  logic [15:0] play_length,
    input  logic [7:0]  left_trig_level,
    input  logic [7:0]  right_trig_level,
    input  logic [7:0]  weak_level,
    input  logic [7:0]  strong_level,
    input  logic [1:0]  send_status,
    // output channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  actuator_mask,
    output logic [6:0]  left_trig_pct,
    output logic [6:0]  right_trig_pct,
    output logic [6:0]  strong_pct,
    output logic [6:0]  weak_pct,
    output logic [7:0]  report_duration,
    output logic [7:0]  report_loops,
    output logic        expects_status
);

    typedef enum logic [1:0] {
        PH_DISABLED = 2'd0,
        PH_DELAYED  = 2'd1,
        PH_ACTIVE   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        WAIT_NONE = 2'd0,
        WAIT_PLAY = 2'd1,
        WAIT_STOP = 2'd2
    } wait_t;

    // configuration registers
    logic        ble_mode_reg;
    logic [15:0] retry_ms_reg;

    // input stage
    logic        stg_valid_reg;
    logic [1:0]  stg_cmd_reg;
    logic [15:0] stg_delay_reg;
    logic [15:0] stg_len_reg;
    logic [7:0]  stg_left_reg;
    logic [7:0]  stg_right_reg;
    logic [7:0]  stg_weak_reg;
    logic [7:0]  stg_strong_reg;
    logic [1:0]  stg_status_reg;

    // scheduler state
    phase_t      phase_reg, phase_next;
    wait_t       wait_reg, wait_next;
    logic [15:0] countdown_reg, countdown_next;
    logic [15:0] held_len_reg, held_len_next;
    logic [7:0]  held_left_reg, held_left_next;
    logic [7:0]  held_right_reg, held_right_next;
    logic [7:0]  held_weak_reg, held_weak_next;
    logic [7:0]  held_strong_reg, held_strong_next;

    // report register
    logic        out_valid_reg, out_valid_next;
    logic [3:0]  mask_reg, mask_next;
    logic [6:0]  left_pct_reg, left_pct_next;
    logic [6:0]  right_pct_reg, right_pct_next;
    logic [6:0]  strong_pct_reg, strong_pct_next;
    logic [6:0]  weak_pct_reg, weak_pct_next;
    logic [7:0]  duration_reg, duration_next;
    logic [7:0]  loops_reg, loops_next;
    logic        expects_reg, expects_next;

    logic        advance;
    logic        process;
    logic        start_play;
    logic        do_play;
    logic        do_stop;
    logic        cfg_write;
    logic [15:0] src_len;
    logic [7:0]  src_left;
    logic [7:0]  src_right;
    logic [7:0]  src_weak;
    logic [7:0]  src_strong;

    // handshakes
    assign advance  = !out_valid_reg || out_ready;
    assign process  = stg_valid_reg && advance;
    assign in_ready = !stg_valid_reg || advance;
    assign pready   = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // register read-back
    always_comb
    begin
        unique case (reg_idx_t'(paddr[2]))
            REG_BLE_MODE: prdata = {31'd0, ble_mode_reg};
            REG_RETRY_MS: prdata = {16'd0, retry_ms_reg};
            default:      prdata = 32'd0;
        endcase
    end

    // a play request starts from its own values, a delayed start from the latched ones
    always_comb
    begin
        if (stg_cmd_reg == CMD_PLAY)
        begin
            src_len    = stg_len_reg;
            src_left   = stg_left_reg;
            src_right  = stg_right_reg;
            src_weak   = stg_weak_reg;
            src_strong = stg_strong_reg;
        end
        else
        begin
            src_len    = held_len_reg;
            src_left   = held_left_reg;
            src_right  = held_right_reg;
            src_weak   = held_weak_reg;
            src_strong = held_strong_reg;
        end
    end

    // scheduler step for the staged word
    always_comb
    begin
        phase_next       = phase_reg;
        wait_next        = wait_reg;
        countdown_next   = countdown_reg;
        held_len_next    = held_len_reg;
        held_left_next   = held_left_reg;
        held_right_next  = held_right_reg;
        held_weak_next   = held_weak_reg;
        held_strong_next = held_strong_reg;
        start_play       = 1'b0;
        do_play          = 1'b0;
        do_stop          = 1'b0;

        case (stg_cmd_reg)
            CMD_TICK:
            begin
                if (wait_reg == WAIT_NONE && phase_reg != PH_DISABLED)
                begin
                    if (countdown_reg > 16'd1)
                        countdown_next = countdown_reg - 16'd1;
                    else
                    begin
                        countdown_next = 16'd0;
                        if (phase_reg == PH_DELAYED)
                            start_play = 1'b1;
                        else
                            do_stop = 1'b1;
                    end
                end
            end
            CMD_PLAY:
            begin
                wait_next        = WAIT_NONE;
                countdown_next   = 16'd0;
                held_len_next    = stg_len_reg;
                held_left_next   = stg_left_reg;
                held_right_next  = stg_right_reg;
                held_weak_next   = stg_weak_reg;
                held_strong_next = stg_strong_reg;
                if (stg_delay_reg == 16'd0)
                    start_play = 1'b1;
                else
                begin
                    phase_next     = PH_DELAYED;
                    countdown_next = stg_delay_reg;
                end
            end
            CMD_STATUS:
            begin
                if (wait_reg != WAIT_NONE)
                begin
                    wait_next = WAIT_NONE;
                    if (stg_status_reg == STATUS_DISALLOWED)
                    begin
                        // resend after the retry wait
                        phase_next     = (wait_reg == WAIT_PLAY) ? PH_DELAYED : PH_ACTIVE;
                        countdown_next = retry_ms_reg;
                    end
                    else if (stg_status_reg == STATUS_OK && wait_reg == WAIT_PLAY)
                    begin
                        phase_next     = PH_ACTIVE;
                        countdown_next = held_len_reg;
                    end
                    else
                    begin
                        phase_next     = PH_DISABLED;
                        countdown_next = 16'd0;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // zero duration turns a start into a stop, or into nothing when disabled
        if (start_play)
        begin
            if (src_len == 16'd0)
                do_stop = (phase_reg != PH_DISABLED);
            else
                do_play = 1'b1;
        end

        if (do_play)
        begin
            phase_next     = PH_ACTIVE;
            wait_next      = ble_mode_reg ? WAIT_PLAY : WAIT_NONE;
            countdown_next = ble_mode_reg ? 16'd0 : src_len;
        end
        if (do_stop)
        begin
            phase_next = PH_DISABLED;
            wait_next  = ble_mode_reg ? WAIT_STOP : WAIT_NONE;
        end
    end

    // report payload
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (process)
            out_valid_next = do_play || do_stop;
        expects_next = ble_mode_reg;
        if (do_play)
        begin
            mask_next       = {src_left != 8'd0, src_right != 8'd0,
                               src_strong != 8'd0, src_weak != 8'd0};
            left_pct_next   = to_pct(src_left);
            right_pct_next  = to_pct(src_right);
            strong_pct_next = to_pct(src_strong);
            weak_pct_next   = to_pct(src_weak);
            duration_next   = PLAY_DURATION_CODE;
            loops_next      = PLAY_LOOPS;
        end
        else
        begin
            mask_next       = MASK_ALL_OFF;
            left_pct_next   = 7'd0;
            right_pct_next  = 7'd0;
            strong_pct_next = 7'd0;
            weak_pct_next   = 7'd0;
            duration_next   = 8'd0;
            loops_next      = 8'd0;
        end
    end

    // state, stages and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ble_mode_reg    <= 1'b0;
            retry_ms_reg    <= RETRY_RESET;
            stg_valid_reg   <= 1'b0;
            stg_cmd_reg     <= CMD_TICK;
            stg_delay_reg   <= 16'd0;
            stg_len_reg     <= 16'd0;
            stg_left_reg    <= 8'd0;
            stg_right_reg   <= 8'd0;
            stg_weak_reg    <= 8'd0;
            stg_strong_reg  <= 8'd0;
            stg_status_reg  <= STATUS_OK;
            phase_reg       <= PH_DISABLED;
            wait_reg        <= WAIT_NONE;
            countdown_reg   <= 16'd0;
            held_len_reg    <= 16'd0;
            held_left_reg   <= 8'd0;
            held_right_reg  <= 8'd0;
            held_weak_reg   <= 8'd0;
            held_strong_reg <= 8'd0;
            out_valid_reg   <= 1'b0;
            mask_reg        <= 4'd0;
            left_pct_reg    <= 7'd0;
            right_pct_reg   <= 7'd0;
            strong_pct_reg  <= 7'd0;
            weak_pct_reg    <= 7'd0;
            duration_reg    <= 8'd0;
            loops_reg       <= 8'd0;
            expects_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (reg_idx_t'(paddr[2]))
                    REG_BLE_MODE: ble_mode_reg <= pwdata[0];
                    REG_RETRY_MS: retry_ms_reg <= pwdata[15:0];
                    default:
                    begin
                    end
                endcase
            end

            if (in_ready)
                stg_valid_reg <= in_valid;
            if (in_valid && in_ready)
            begin
                stg_cmd_reg    <= command;
                stg_delay_reg  <= start_delay;
                stg_len_reg    <= play_length;
                stg_left_reg   <= left_trig_level;
                stg_right_reg  <= right_trig_level;
                stg_weak_reg   <= weak_level;
                stg_strong_reg <= strong_level;
                stg_status_reg <= send_status;
            end

            if (process)
            begin
                phase_reg       <= phase_next;
                wait_reg        <= wait_next;
                countdown_reg   <= countdown_next;
                held_len_reg    <= held_len_next;
                held_left_reg   <= held_left_next;
                held_right_reg  <= held_right_next;
                held_weak_reg   <= held_weak_next;
                held_strong_reg <= held_strong_next;
            end

            out_valid_reg <= out_valid_next;
            if (process && (do_play || do_stop))
            begin
                mask_reg       <= mask_next;
                left_pct_reg   <= left_pct_next;
                right_pct_reg  <= right_pct_next;
                strong_pct_reg <= strong_pct_next;
                weak_pct_reg   <= weak_pct_next;
                duration_reg   <= duration_next;
                loops_reg      <= loops_next;
                expects_reg    <= expects_next;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign actuator_mask   = mask_reg;
    assign left_trig_pct   = left_pct_reg;
    assign right_trig_pct  = right_pct_reg;
    assign strong_pct      = strong_pct_reg;
    assign weak_pct        = weak_pct_reg;
    assign report_duration = duration_reg;
    assign report_loops    = loops_reg;
    assign expects_status  = expects_reg;

`ifndef SYNTHESIS
    // a play report in flight keeps the rumble active with no countdown running
    assert property (@(posedge clk) disable iff (!rst_n)
        wait_reg == WAIT_PLAY |-> phase_reg == PH_ACTIVE && countdown_reg == 16'd0)
        else $error("awaiting play status outside active phase");

    // an all-off report in flight leaves the block disabled
    assert property (@(posedge clk) disable iff (!rst_n)
        wait_reg == WAIT_STOP |-> phase_reg == PH_DISABLED)
        else $error("awaiting stop status while not disabled");

    // a disabled block never holds a countdown
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DISABLED |-> countdown_reg == 16'd0)
        else $error("countdown left running while disabled");

    // all-off reports carry every actuator bit and no level
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && duration_reg == 8'd0 |->
            mask_reg == MASK_ALL_OFF && loops_reg == 8'd0 && weak_pct_reg == 7'd0)
        else $error("malformed all-off report");

    // the input side only stalls when both stages are full and the output is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> stg_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled without backpressure");
`endif

endmodule

// ===== bench/rumble_delay_duration_scheduler_tb.sv =====
// Self-checking testbench for the rumble delay/duration scheduler.
module rumble_delay_duration_scheduler_tb;
    import rdds_pkg::*;

    // Codes the package leaves unnamed
    localparam logic [1:0] CMD_IGNORED  = 2'd3;
    localparam logic [1:0] STATUS_ERROR = 2'd2;
    localparam logic [1:0] STATUS_SPARE = 2'd3;

    // Scheduler phases and awaited link answers
    typedef enum logic [1:0] {PH_OFF, PH_DELAYED, PH_ACTIVE} phase_e;
    typedef enum logic [1:0] {AW_NONE, AW_PLAY, AW_STOP} await_e;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] dly;
        logic [15:0] len;
        logic [7:0]  left;
        logic [7:0]  right;
        logic [7:0]  weak_lvl;
        logic [7:0]  strong_lvl;
        logic [1:0]  status;
    } word_t;

    typedef struct packed {
        logic [3:0] mask;
        logic [6:0] left_pct;
        logic [6:0] right_pct;
        logic [6:0] strong_pct;
        logic [6:0] weak_pct;
        logic [7:0] dur;
        logic [7:0] loops;
        logic       expects;
    } report_t;

    typedef struct packed {
        logic        is_cfg;
        reg_idx_t    cfg_sel;
        logic [15:0] cfg_val;
        word_t       w;
        logic        typed;
        report_t     exp;
    } row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  command;
    logic [15:0] start_delay, play_length;
    logic [7:0]  left_trig_level, right_trig_level, weak_level, strong_level;
    logic [1:0]  send_status;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  actuator_mask;
    logic [6:0]  left_trig_pct, right_trig_pct, strong_pct, weak_pct;
    logic [7:0]  report_duration, report_loops;
    logic        expects_status;

    // Predictor state and its copy of the registers
    phase_e      sched_phase;
    await_e      sched_wait;
    logic [15:0] sched_count;
    logic [15:0] sched_len;
    logic [7:0]  lvl_left, lvl_right, lvl_weak, lvl_strong;
    logic        cfg_ble;
    logic [15:0] cfg_retry;

    report_t pending_reports[$];
    row_t    plan[$];
    int      errors = 0;
    bit      steady = 1'b0;

    rumble_delay_duration_scheduler DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .command(command),
        .start_delay(start_delay), .play_length(play_length),
        .left_trig_level(left_trig_level), .right_trig_level(right_trig_level),
        .weak_level(weak_level), .strong_level(strong_level),
        .send_status(send_status),
        .out_valid(out_valid), .out_ready(out_ready),
        .actuator_mask(actuator_mask), .left_trig_pct(left_trig_pct),
        .right_trig_pct(right_trig_pct), .strong_pct(strong_pct),
        .weak_pct(weak_pct), .report_duration(report_duration),
        .report_loops(report_loops), .expects_status(expects_status)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Run limit, far above the slowest correct run
    initial
    begin
        #4000000;
        $display("status: fail");
        $finish;
    end

    function automatic report_t mk_report(logic [3:0] mask, int l, int r, int s, int wk,
                                          logic [7:0] dur, logic [7:0] loops, logic ex);
        report_t rep;
        rep.mask       = mask;
        rep.left_pct   = 7'(l);
        rep.right_pct  = 7'(r);
        rep.strong_pct = 7'(s);
        rep.weak_pct   = 7'(wk);
        rep.dur        = dur;
        rep.loops      = loops;
        rep.expects    = ex;
        return rep;
    endfunction

    function automatic logic [6:0] percent_of(logic [7:0] level);
        int unsigned scaled;
        scaled = (int'(level) * 100) / 255;
        return 7'(scaled);
    endfunction

    // All-off report; phase drops to disabled
    function automatic report_t all_off();
        sched_phase = PH_OFF;
        sched_wait  = cfg_ble ? AW_STOP : AW_NONE;
        return mk_report(MASK_ALL_OFF, 0, 0, 0, 0, 8'd0, 8'd0, cfg_ble);
    endfunction

    // Start playing the latched levels, or stop when the held length is zero
    task automatic start_play(output bit fired, output report_t rep);
        logic [3:0] mask;
        fired = 1'b0;
        rep   = '0;
        mask  = '0;
        if (sched_len == 16'd0)
        begin
            if (sched_phase != PH_OFF)
            begin
                rep   = all_off();
                fired = 1'b1;
            end
        end
        else
        begin
            mask[0] = (lvl_weak != 8'd0);
            mask[1] = (lvl_strong != 8'd0);
            mask[2] = (lvl_right != 8'd0);
            mask[3] = (lvl_left != 8'd0);
            rep = mk_report(mask, percent_of(lvl_left), percent_of(lvl_right),
                            percent_of(lvl_strong), percent_of(lvl_weak),
                            PLAY_DURATION_CODE, PLAY_LOOPS, cfg_ble);
            sched_wait  = cfg_ble ? AW_PLAY : AW_NONE;
            sched_phase = PH_ACTIVE;
            sched_count = cfg_ble ? 16'd0 : sched_len;
            fired = 1'b1;
        end
    endtask

    // Predict the report, if any, caused by one accepted word
    task automatic schedule_step(input word_t w, output bit fired, output report_t rep);
        await_e kind;
        fired = 1'b0;
        rep   = '0;
        case (w.cmd)
            CMD_TICK:
            begin
                if (sched_wait == AW_NONE && sched_phase != PH_OFF)
                begin
                    if (sched_count > 16'd1)
                        sched_count = sched_count - 16'd1;
                    else
                    begin
                        sched_count = 16'd0;
                        if (sched_phase == PH_DELAYED)
                            start_play(fired, rep);
                        else
                        begin
                            rep   = all_off();
                            fired = 1'b1;
                        end
                    end
                end
            end
            CMD_PLAY:
            begin
                sched_wait  = AW_NONE;
                sched_count = 16'd0;
                sched_len   = w.len;
                lvl_left    = w.left;
                lvl_right   = w.right;
                lvl_weak    = w.weak_lvl;
                lvl_strong  = w.strong_lvl;
                if (w.dly == 16'd0)
                    start_play(fired, rep);
                else
                begin
                    sched_phase = PH_DELAYED;
                    sched_count = w.dly;
                end
            end
            CMD_STATUS:
            begin
                kind = sched_wait;
                if (kind != AW_NONE)
                begin
                    sched_wait = AW_NONE;
                    if (w.status == STATUS_DISALLOWED)
                    begin
                        sched_phase = (kind == AW_PLAY) ? PH_DELAYED : PH_ACTIVE;
                        sched_count = cfg_retry;
                    end
                    else if (kind == AW_PLAY && w.status == STATUS_OK)
                    begin
                        sched_phase = PH_ACTIVE;
                        sched_count = sched_len;
                    end
                    else
                    begin
                        sched_phase = PH_OFF;
                        sched_count = 16'd0;
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Offer one word, wait for its handshake, then predict
    task automatic push_word(input word_t w, input logic typed, input report_t typed_rep);
        bit      fired;
        report_t rep;
        @(negedge clk);
        while (!steady && $urandom_range(99) < 22)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        command          = w.cmd;
        start_delay      = w.dly;
        play_length      = w.len;
        left_trig_level  = w.left;
        right_trig_level = w.right;
        weak_level       = w.weak_lvl;
        strong_level     = w.strong_lvl;
        send_status      = w.status;
        in_valid         = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        schedule_step(w, fired, rep);
        if (typed)
            pending_reports.push_back(typed_rep);
        else if (fired)
            pending_reports.push_back(rep);
    endtask

    // Hold the sender until every expected report is in, then let the pipe empty
    task automatic settle_reports();
        int waited;
        waited = 0;
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_reports.size() != 0 && waited < 5000)
        begin
            @(negedge clk);
            waited++;
        end
        if (pending_reports.size() != 0)
        begin
            $display("%0t missing reports: expected %0d more, actual 0",
                     $time, pending_reports.size());
            errors += pending_reports.size();
            pending_reports.delete();
        end
        repeat (6) @(negedge clk);
    endtask

    task automatic apb_write(input reg_idx_t sel, input logic [15:0] val);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {sel, 2'b00};
        pwdata  = {16'd0, val};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (sel == REG_BLE_MODE)
            cfg_ble = val[0];
        else
            cfg_retry = val;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    function automatic row_t item_row(logic [1:0] cmd, logic [15:0] dly, logic [15:0] len,
                                      logic [7:0] l, logic [7:0] r, logic [7:0] wk,
                                      logic [7:0] st, logic [1:0] stat);
        row_t row;
        row = '0;
        row.w.cmd        = cmd;
        row.w.dly        = dly;
        row.w.len        = len;
        row.w.left       = l;
        row.w.right      = r;
        row.w.weak_lvl   = wk;
        row.w.strong_lvl = st;
        row.w.status     = stat;
        return row;
    endfunction

    function automatic row_t checked(row_t row, report_t e);
        row.typed = 1'b1;
        row.exp   = e;
        return row;
    endfunction

    function automatic row_t cfg_row(reg_idx_t sel, logic [15:0] val);
        row_t row;
        row = '0;
        row.is_cfg  = 1'b1;
        row.cfg_sel = sel;
        row.cfg_val = val;
        return row;
    endfunction

    function automatic logic [15:0] pick_span(int zero_pct, int short_hi, int mid_hi);
        int p;
        p = $urandom_range(99);
        if (p < zero_pct)
            return 16'd0;
        else if (p < 80)
            return 16'($urandom_range(short_hi, 1));
        else if (p < 95)
            return 16'($urandom_range(mid_hi, short_hi + 1));
        return 16'($urandom);
    endfunction

    function automatic logic [7:0] pick_level();
        int p;
        p = $urandom_range(99);
        if (p < 15)
            return 8'd0;
        else if (p < 30)
            return 8'hff;
        return 8'($urandom);
    endfunction

    // Random word, weighted by what the scheduler is waiting for
    function automatic word_t rand_word();
        word_t w;
        int    p;
        int    q;
        w            = '0;
        w.dly        = pick_span(35, 8, 64);
        w.len        = pick_span(10, 10, 100);
        w.left       = pick_level();
        w.right      = pick_level();
        w.weak_lvl   = pick_level();
        w.strong_lvl = pick_level();
        q = $urandom_range(99);
        w.status = (q < 45) ? STATUS_OK : (q < 80) ? STATUS_DISALLOWED :
                   (q < 92) ? STATUS_ERROR : STATUS_SPARE;
        p = $urandom_range(99);
        if (sched_wait != AW_NONE)
            w.cmd = (p < 70) ? CMD_STATUS : (p < 85) ? CMD_TICK :
                    (p < 97) ? CMD_PLAY : CMD_IGNORED;
        else if (sched_phase == PH_OFF)
            w.cmd = (p < 65) ? CMD_PLAY : (p < 80) ? CMD_TICK :
                    (p < 93) ? CMD_STATUS : CMD_IGNORED;
        else
            w.cmd = (p < 72) ? CMD_TICK : (p < 88) ? CMD_PLAY :
                    (p < 95) ? CMD_STATUS : CMD_IGNORED;
        return w;
    endfunction

    task automatic cmp_field(input string name, input int unsigned want,
                             input int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t %s: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Receiver: ready drops at random outside the steady stretch
    always @(negedge clk)
        out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 22);

    // Report checker
    always @(posedge clk)
    begin
        report_t got;
        report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {actuator_mask, left_trig_pct, right_trig_pct, strong_pct, weak_pct,
                   report_duration, report_loops, expects_status};
            if (pending_reports.size() == 0)
            begin
                errors++;
                $display("%0t unexpected report: expected none, actual mask %0d dur %0d",
                         $time, got.mask, got.dur);
            end
            else
            begin
                want = pending_reports.pop_front();
                cmp_field("actuator_mask", want.mask, got.mask);
                cmp_field("left_trig_pct", want.left_pct, got.left_pct);
                cmp_field("right_trig_pct", want.right_pct, got.right_pct);
                cmp_field("strong_pct", want.strong_pct, got.strong_pct);
                cmp_field("weak_pct", want.weak_pct, got.weak_pct);
                cmp_field("report_duration", want.dur, got.dur);
                cmp_field("report_loops", want.loops, got.loops);
                cmp_field("expects_status", want.expects, got.expects);
            end
        end
    end

    // Stimulus
    initial
    begin
        report_t full_on;
        report_t off_plain;
        report_t no_motor;
        int      ble_set[8];
        int      retry_set[8];

        ble_set   = '{0, 1, 1, 0, 1, 1, 0, 1};
        retry_set = '{50, 1, 65535, 1, 3, 0, 65535, 17};

        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_valid = 1'b0; command = CMD_TICK; start_delay = '0; play_length = '0;
        left_trig_level = '0; right_trig_level = '0; weak_level = '0; strong_level = '0;
        send_status = STATUS_OK;

        sched_phase = PH_OFF; sched_wait = AW_NONE; sched_count = '0; sched_len = '0;
        lvl_left = '0; lvl_right = '0; lvl_weak = '0; lvl_strong = '0;
        cfg_ble = 1'b0; cfg_retry = RETRY_RESET;

        full_on   = mk_report(4'hf, 100, 100, 100, 100, PLAY_DURATION_CODE, PLAY_LOOPS, 1'b0);
        off_plain = mk_report(MASK_ALL_OFF, 0, 0, 0, 0, 8'd0, 8'd0, 1'b0);
        no_motor  = mk_report(4'h0, 0, 0, 0, 0, PLAY_DURATION_CODE, PLAY_LOOPS, 1'b0);

        // Directed: non-BLE corner cases, then BLE retries with a zero retry time
        plan.push_back(item_row(CMD_TICK, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, STATUS_OK));
        plan.push_back(item_row(CMD_STATUS, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, STATUS_OK));
        plan.push_back(item_row(CMD_IGNORED, 16'hffff, 16'hffff, 8'hff, 8'hff, 8'hff,
                                8'hff, STATUS_SPARE));
        plan.push_back(item_row(CMD_PLAY, 16'd0, 16'd0, 8'h55, 8'h55, 8'h55, 8'h55,
                                STATUS_OK));
        plan.push_back(checked(item_row(CMD_PLAY, 16'd0, 16'd2, 8'hff, 8'hff, 8'hff, 8'hff,
                                        STATUS_OK), full_on));
        plan.push_back(item_row(CMD_TICK, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, STATUS_OK));
        plan.push_back(checked(item_row(CMD_TICK, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                                        STATUS_OK), off_plain));
        plan.push_back(item_row(CMD_PLAY, 16'd1, 16'd1, 8'd1, 8'd128, 8'd0, 8'd254,
                                STATUS_OK));
        plan.push_back(item_row(CMD_TICK, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, STATUS_OK));
        plan.push_back(item_row(CMD_PLAY, 16'hffff, 16'd3, 8'd7, 8'd200, 8'd99, 8'd3,
                                STATUS_OK));
        plan.push_back(checked(item_row(CMD_PLAY, 16'd0, 16'hffff, 8'd0, 8'd0, 8'd0, 8'd0,
                                        STATUS_OK), no_motor));
        plan.push_back(checked(item_row(CMD_PLAY, 16'd0, 16'd0, 8'd9, 8'd9, 8'd9, 8'd9,
                                        STATUS_OK), off_plain));
        plan.push_back(cfg_row(REG_BLE_MODE, 16'd1));
        plan.push_back(cfg_row(REG_RETRY_MS, 16'd0));
        plan.push_back(item_row(CMD_PLAY, 16'd0, 16'd1, 8'hff, 8'd0, 8'hff, 8'd0, STATUS_OK));
        plan.push_back(item_row(CMD_TICK, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, STATUS_OK));
        plan.push_back(item_row(CMD_STATUS, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                                STATUS_DISALLOWED));
        plan.push_back(item_row(CMD_TICK, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, STATUS_OK));
        plan.push_back(item_row(CMD_STATUS, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, STATUS_OK));
        plan.push_back(item_row(CMD_TICK, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, STATUS_OK));
        plan.push_back(item_row(CMD_STATUS, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                                STATUS_DISALLOWED));
        plan.push_back(item_row(CMD_TICK, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, STATUS_OK));
        plan.push_back(item_row(CMD_STATUS, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                                STATUS_SPARE));
        plan.push_back(item_row(CMD_PLAY, 16'd0, 16'd4, 8'd37, 8'd2, 8'd0, 8'd170, STATUS_OK));
        plan.push_back(item_row(CMD_PLAY, 16'd0, 16'd0, 8'd1, 8'd1, 8'd1, 8'd1, STATUS_OK));
        plan.push_back(item_row(CMD_STATUS, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, STATUS_OK));
        plan.push_back(item_row(CMD_PLAY, 16'd0, 16'd4, 8'd0, 8'd51, 8'd128, 8'd0, STATUS_OK));
        plan.push_back(item_row(CMD_STATUS, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                                STATUS_ERROR));
        plan.push_back(item_row(CMD_STATUS, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, STATUS_OK));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                settle_reports();
                apb_write(plan[i].cfg_sel, plan[i].cfg_val);
            end
            else
                push_word(plan[i].w, plan[i].typed, plan[i].exp);
        end

        // Random phases, each under its own register setting
        for (int ph = 0; ph < 8; ph++)
        begin
            settle_reports();
            apb_write(REG_BLE_MODE, 16'(ble_set[ph]));
            apb_write(REG_RETRY_MS, 16'(retry_set[ph]));
            steady = (ph == 3);
            for (int n = 0; n < 230; n++)
            begin
                if (n == 115)
                    settle_reports();
                push_word(rand_word(), 1'b0, '0);
            end
        end
        steady = 1'b0;
        settle_reports();

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
